FILE: rtl/core/prr_pkg.sv
// Shared constants, register codes and controller/datapath types for the resampler.
`timescale 1ns / 1ps

package prr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int DEPTH    = 256;
  localparam int ADDR_W   = 8;
  localparam int RATE_W   = 6;
  localparam int TAPS_W   = 9;
  localparam int PHASE_W  = 5;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + ADDR_W;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;

  localparam logic [RATE_W-1:0] MAX_RATE = 6'd32;
  localparam logic [TAPS_W-1:0] MAX_TAPS = 9'd256;

  typedef enum logic [IDX_W-1:0] {
    REG_INTERP     = 3'd0,
    REG_DECIM      = 3'd1,
    REG_TAPS       = 3'd2,
    REG_COEF_INDEX = 3'd3,
    REG_COEF_VALUE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              clear_wr;
    logic [ADDR_W-1:0] clr_addr;
    logic              push;
    logic              tap_go;
    logic [ADDR_W-1:0] tap_t;
    logic [ADDR_W-1:0] tap_k;
    logic              acc_clear;
    logic              emit;
    logic              emit_last;
  } prr_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } prr_status_t;

endpackage

FILE: rtl/core/prr_datapath.sv
// Datapath: delay lines, coefficient memory, complex MAC pair and output register.
`timescale 1ns / 1ps

module prr_datapath import prr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  prr_cmd_t                   cmd,
  output prr_status_t                status,
  input  logic                       coef_wr,
  input  logic [ADDR_W-1:0]          coef_addr,
  input  logic signed [COEF_W-1:0]   coef_data,
  input  logic signed [SAMPLE_W-1:0] in_real,
  input  logic signed [SAMPLE_W-1:0] in_imag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_real,
  output logic signed [SAMPLE_W-1:0] out_imag,
  output logic                       last_of_run
);

  localparam int SH_W = ACC_W - (COEF_W - 1);

  logic signed [COEF_W-1:0]   coef_mem [DEPTH];
  logic signed [SAMPLE_W-1:0] dline_re [DEPTH];
  logic signed [SAMPLE_W-1:0] dline_im [DEPTH];

  logic [ADDR_W-1:0]          head;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          rd_pos;
  logic signed [SAMPLE_W-1:0] wr_re;
  logic signed [SAMPLE_W-1:0] wr_im;
  logic signed [COEF_W-1:0]   coef_q;
  logic signed [SAMPLE_W-1:0] dre_q;
  logic signed [SAMPLE_W-1:0] dim_q;
  logic signed [PROD_W-1:0]   prod_re;
  logic signed [PROD_W-1:0]   prod_im;
  logic signed [ACC_W-1:0]    acc_re;
  logic signed [ACC_W-1:0]    acc_im;
  logic                       v1;
  logic                       v2;
  logic signed [SAMPLE_W-1:0] res_re;
  logic signed [SAMPLE_W-1:0] res_im;

  // Round half up at bit 14, drop 15 fraction bits, then clip to Q1.15.
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [SH_W-1:0]  s;
    r = a + (ACC_W'(1) <<< (COEF_W - 2));
    s = r[ACC_W-1:COEF_W-1];
    if (s > SH_W'(signed'((1 <<< (SAMPLE_W - 1)) - 1))) begin
      round_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (s < -SH_W'(signed'(1 <<< (SAMPLE_W - 1)))) begin
      round_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      round_sat = s[SAMPLE_W-1:0];
    end
  endfunction

  assign wr_addr = cmd.clear_wr ? cmd.clr_addr : head + ADDR_W'(1);
  assign wr_re   = cmd.clear_wr ? '0 : in_real;
  assign wr_im   = cmd.clear_wr ? '0 : in_imag;
  assign rd_pos  = head - cmd.tap_k;
  assign res_re  = round_sat(acc_re);
  assign res_im  = round_sat(acc_im);

  assign status.busy     = v1 | v2;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[coef_addr] <= coef_data;
    end
    if (cmd.tap_go) begin
      coef_q <= coef_mem[cmd.tap_t];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr || cmd.push) begin
      dline_re[wr_addr] <= wr_re;
      dline_im[wr_addr] <= wr_im;
    end
    if (cmd.tap_go) begin
      dre_q <= dline_re[rd_pos];
      dim_q <= dline_im[rd_pos];
    end
  end

  always_ff @(posedge clk) begin
    prod_re <= dre_q * coef_q;
    prod_im <= dim_q * coef_q;
    if (cmd.acc_clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2) begin
      acc_re <= acc_re + ACC_W'(prod_re);
      acc_im <= acc_im + ACC_W'(prod_im);
    end
    if (cmd.emit) begin
      out_real    <= res_re;
      out_imag    <= res_im;
      last_of_run <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        head <= head + ADDR_W'(1);
      end
      v1 <= cmd.tap_go;
      v2 <= v1;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/prr_ctrl.sv
// Controller: clearing sweep, phase tracking, tap sequencing and output pacing.
`timescale 1ns / 1ps

module prr_ctrl import prr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [RATE_W-1:0] interp,
  input  logic [RATE_W-1:0] decim,
  input  logic [TAPS_W-1:0] taps,
  input  logic              in_valid,
  output logic              in_stall,
  output prr_cmd_t          cmd,
  input  prr_status_t       status
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PHMOD, S_TAPS, S_DRAIN, S_EMIT, S_ADV
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [PHASE_W-1:0] skip;
  logic [PHASE_W-1:0] phase;
  logic [TAPS_W-1:0]  t;
  logic [ADDR_W-1:0]  k;
  logic [RATE_W-1:0]  phw;
  logic [RATE_W-1:0]  adv;
  logic [RATE_W-1:0]  ph_ext;
  logic [RATE_W-1:0]  ph_sum;
  logic [RATE_W-1:0]  ph_red;
  logic               accept;

  assign ph_ext   = {1'b0, phase};
  assign ph_sum   = ph_ext + decim;
  assign ph_red   = ph_ext - interp;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.clr_addr  = clr_cnt;
    cmd.tap_t     = t[ADDR_W-1:0];
    cmd.tap_k     = k;
    cmd.emit_last = (ph_sum >= interp);
    unique case (state)
      S_CLEAR: cmd.clear_wr  = 1'b1;
      S_IDLE:  cmd.push      = accept;
      S_PHMOD: cmd.acc_clear = (ph_ext < interp);
      S_TAPS:  cmd.tap_go    = (t < taps);
      S_EMIT:  cmd.emit      = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      skip    <= '0;
      phase   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == {ADDR_W{1'b1}}) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (skip != '0) skip <= skip - PHASE_W'(1);
            else state <= S_PHMOD;
          end
        end
        S_PHMOD: begin
          // Bring the phase below a possibly changed interpolation factor.
          if (ph_ext >= interp) begin
            phase <= ph_red[PHASE_W-1:0];
          end else begin
            t     <= TAPS_W'(phase);
            k     <= '0;
            state <= S_TAPS;
          end
        end
        S_TAPS: begin
          if (t < taps) begin
            t <= t + TAPS_W'(interp);
            k <= k + ADDR_W'(1);
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!status.busy) state <= S_EMIT;
        end
        S_EMIT: begin
          if (status.out_free) begin
            phw   <= ph_sum;
            adv   <= '0;
            state <= S_ADV;
          end
        end
        S_ADV: begin
          if (phw >= interp) begin
            phw <= phw - interp;
            adv <= adv + RATE_W'(1);
          end else begin
            phase <= phw[PHASE_W-1:0];
            if (adv == '0) begin
              state <= S_PHMOD;
            end else begin
              skip  <= adv[PHASE_W-1:0] - PHASE_W'(1);
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/polyphase_rational_resampler_top.sv
// Top level of the L/M polyphase resampler: configuration registers and block wiring.
//
//  Channel  Signals                               Direction
//  input    in_valid, in_stall, in_real, in_imag  word in, stall out
//  output   out_valid, out_stall, out_real,       word out, stall in
//           out_imag, last_of_run
//  config   cfg_wr_en, cfg_index, cfg_data        write only
//
// After reset a sweep over all 256 addresses zeroes both delay lines; no word is taken meanwhile.
// Each output takes a phase check (repeated once per L subtracted after L shrinks),
// one tap read for every k with p+k*L < T (at most ceil(T/L)), a tap-loop exit,
// a drain until the MAC pipeline is empty, an emit and a phase update that subtracts L
// from p+M until the sum falls below L. A skipped word is only taken and counted down.
// Words are handled one at a time; a stalled output word holds the block at its next emit.
`timescale 1ns / 1ps

module polyphase_rational_resampler_top import prr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_real,
  input  logic signed [SAMPLE_W-1:0] in_imag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_real,
  output logic signed [SAMPLE_W-1:0] out_imag,
  output logic                       last_of_run,
  input  logic                       cfg_wr_en,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  logic [RATE_W-1:0] interp_raw;
  logic [RATE_W-1:0] decim_raw;
  logic [TAPS_W-1:0] taps_raw;
  logic [ADDR_W-1:0] coef_index;
  logic [RATE_W-1:0] interp;
  logic [RATE_W-1:0] decim;
  logic [TAPS_W-1:0] taps;
  logic              coef_wr;
  prr_cmd_t          cmd;
  prr_status_t       status;

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] v);
    if (v == '0) clamp_rate = RATE_W'(1);
    else if (v > MAX_RATE) clamp_rate = MAX_RATE;
    else clamp_rate = v;
  endfunction

  assign interp  = clamp_rate(interp_raw);
  assign decim   = clamp_rate(decim_raw);
  assign taps    = (taps_raw > MAX_TAPS) ? MAX_TAPS : taps_raw;
  assign coef_wr = cfg_wr_en && (cfg_index == REG_COEF_VALUE);

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_raw <= RATE_W'(1);
      decim_raw  <= RATE_W'(1);
      taps_raw   <= TAPS_W'(1);
      coef_index <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INTERP:     interp_raw <= cfg_data[RATE_W-1:0];
        REG_DECIM:      decim_raw  <= cfg_data[RATE_W-1:0];
        REG_TAPS:       taps_raw   <= cfg_data[TAPS_W-1:0];
        REG_COEF_INDEX: coef_index <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  prr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .interp   (interp),
    .decim    (decim),
    .taps     (taps),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  prr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .coef_wr     (coef_wr),
    .coef_addr   (coef_index),
    .coef_data   (cfg_data[COEF_W-1:0]),
    .in_real     (in_real),
    .in_imag     (in_imag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_real    (out_real),
    .out_imag    (out_imag),
    .last_of_run (last_of_run)
  );

endmodule
